// ===== src/sed_pkg.sv =====
// Shared widths and pipeline side-data types for the symmetric 2x2
// eigendecomposition core. No dependencies.
`default_nettype none
package sed_pkg;

  localparam int IN_W    = 32;  // Q16.16 matrix entries
  localparam int VAL_W   = 34;  // Q18.16 eigenvalues
  localparam int VEC_W   = 32;  // Q2.30 vector elements
  localparam int FRAC_W  = 30;  // fraction bits of the vector format
  localparam int RAD_W   = 72;  // radicand width of both square roots
  localparam int ROOT_W  = RAD_W / 2;
  localparam int MAG_W   = 34;  // |s| magnitude width
  localparam int RMAG_W  = 33;  // |2b| magnitude width
  localparam int QUO_W   = FRAC_W + 1;

  localparam logic [VEC_W-1:0] ONE_Q30 = VEC_W'(1) << FRAC_W;

  // carried through the norm square root
  typedef struct packed {
    logic signed [VAL_W-1:0] l1;
    logic signed [VAL_W-1:0] l2;
    logic [MAG_W-1:0]        us;
    logic [RMAG_W-1:0]       ur;
    logic                    bneg;
    logic                    diag;
    logic                    agt;
  } mid_t;

  // carried through the two-lane divider
  typedef struct packed {
    logic signed [VAL_W-1:0] l1;
    logic signed [VAL_W-1:0] l2;
    logic                    bneg;
    logic                    diag;
    logic                    agt;
  } tail_t;

endpackage
`default_nettype wire

// ===== src/sym2x2_eigen_decomposition_core.sv =====
// Symmetric 2x2 eigendecomposition, fully pipelined: one item per cycle.
// Stages: two 36-stage square roots, a 31-stage divider, and six stages of
// squaring, summing and output. Depends on sed_pkg.
// Sustained rate is one item per clock; the whole pipeline holds while a
// result waits at the output, so in_ready = !out_valid || out_ready.
`default_nettype none
module sym2x2_eigen_decomposition_core
  import sed_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     in_valid,
  output logic                          in_ready,
  input  wire logic signed [IN_W-1:0]   entry_a,
  input  wire logic signed [IN_W-1:0]   entry_b,
  input  wire logic signed [IN_W-1:0]   entry_d,
  output logic                          out_valid,
  input  wire logic                     out_ready,
  output logic signed [VAL_W-1:0]       larger_eigenvalue,
  output logic signed [VAL_W-1:0]       smaller_eigenvalue,
  output logic signed [VEC_W-1:0]       vec_elem_0,
  output logic signed [VEC_W-1:0]       vec_elem_1,
  output logic signed [VEC_W-1:0]       vec_elem_2,
  output logic signed [VEC_W-1:0]       vec_elem_3
);
  localparam int ABD_W = 3 * IN_W;

  logic en;
  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  // stage A: squares of |a-d| and |2b|
  logic signed [IN_W:0] diff_in;
  logic signed [IN_W:0] r2_in;
  logic [IN_W-1:0]      ud_in;
  logic [IN_W:0]        ur_in;
  always_comb begin
    diff_in = {entry_a[IN_W-1], entry_a} - {entry_d[IN_W-1], entry_d};
    r2_in   = {entry_b, 1'b0};
    ud_in   = diff_in[IN_W] ? IN_W'(-diff_in) : diff_in[IN_W-1:0];
    ur_in   = r2_in[IN_W] ? -r2_in : r2_in;
  end

  logic                  va;
  logic [2*IN_W-1:0]     sq_d;
  logic [2*IN_W+1:0]     sq_r;
  logic [ABD_W-1:0]      abd_a;
  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
    end else if (en) begin
      va <= in_valid;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      sq_d  <= ud_in * ud_in;
      sq_r  <= ur_in * ur_in;
      abd_a <= {entry_a, entry_b, entry_d};
    end
  end

  // stage B: radicand (a-d)^2 + 4b^2
  logic              vb;
  logic [RAD_W-1:0]  rad_b;
  logic [ABD_W-1:0]  abd_b;
  always_ff @(posedge clk) begin
    if (rst) begin
      vb <= 1'b0;
    end else if (en) begin
      vb <= va;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      rad_b <= RAD_W'(sq_d) + RAD_W'(sq_r);
      abd_b <= abd_a;
    end
  end

  logic              v_det;
  logic [ROOT_W-1:0] det;
  logic [ABD_W-1:0]  abd_c;
  sed_sqrt #(.RAD_W(RAD_W), .SIDE_W(ABD_W)) u_sqrt_det (
    .clk, .rst, .en,
    .in_valid (vb),
    .rad      (rad_b),
    .side_in  (abd_b),
    .out_valid(v_det),
    .root     (det),
    .side_out (abd_c)
  );

  // stage C: eigenvalues, s = (a-d) - det, diagonal handling
  logic signed [IN_W-1:0] a_c, b_c, d_c;
  logic signed [IN_W:0]   diff_c;
  logic [ROOT_W+2:0]      us_w;
  logic signed [VAL_W:0]  sum_p, sum_m;
  logic [RMAG_W-1:0]      ur_c;
  logic signed [IN_W:0]   r2_c;
  mid_t                   mid_next;
  always_comb begin
    a_c    = abd_c[ABD_W-1 -: IN_W];
    b_c    = abd_c[2*IN_W-1 -: IN_W];
    d_c    = abd_c[IN_W-1:0];
    diff_c = {a_c[IN_W-1], a_c} - {d_c[IN_W-1], d_c};
    r2_c   = {b_c, 1'b0};
    ur_c   = r2_c[IN_W] ? RMAG_W'(-r2_c) : RMAG_W'(r2_c);
    us_w   = {3'b000, det} - {{(ROOT_W+3-IN_W-1){diff_c[IN_W]}}, diff_c};
    sum_p  = (VAL_W+1)'(a_c) + (VAL_W+1)'(d_c) + $signed({1'b0, det[VAL_W-1:0]});
    sum_m  = (VAL_W+1)'(a_c) + (VAL_W+1)'(d_c) - $signed({1'b0, det[VAL_W-1:0]});
    mid_next.diag = (b_c == '0);
    mid_next.agt  = (a_c > d_c);
    mid_next.bneg = b_c[IN_W-1];
    mid_next.us   = us_w[MAG_W-1:0];
    mid_next.ur   = ur_c;
    if (mid_next.diag) begin
      mid_next.l1 = mid_next.agt ? VAL_W'(a_c) : VAL_W'(d_c);
      mid_next.l2 = mid_next.agt ? VAL_W'(d_c) : VAL_W'(a_c);
    end else begin
      mid_next.l1 = sum_p[VAL_W:1];
      mid_next.l2 = sum_m[VAL_W:1];
    end
  end

  logic vc;
  mid_t mid_c;
  always_ff @(posedge clk) begin
    if (rst) begin
      vc <= 1'b0;
    end else if (en) begin
      vc <= v_det;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      mid_c <= mid_next;
    end
  end

  // stage D: r^2 and s^2
  logic                vd;
  logic [2*RMAG_W-1:0] sq_ur;
  logic [2*MAG_W-1:0]  sq_us;
  mid_t                mid_d;
  always_ff @(posedge clk) begin
    if (rst) begin
      vd <= 1'b0;
    end else if (en) begin
      vd <= vc;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      sq_ur <= mid_c.ur * mid_c.ur;
      sq_us <= mid_c.us * mid_c.us;
      mid_d <= mid_c;
    end
  end

  // stage E: norm radicand
  logic             ve;
  logic [RAD_W-1:0] rad_e;
  mid_t             mid_e;
  always_ff @(posedge clk) begin
    if (rst) begin
      ve <= 1'b0;
    end else if (en) begin
      ve <= vd;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      rad_e <= RAD_W'(sq_ur) + RAD_W'(sq_us);
      mid_e <= mid_d;
    end
  end

  logic              v_norm;
  logic [ROOT_W-1:0] norm;
  mid_t              mid_f;
  sed_sqrt #(.RAD_W(RAD_W), .SIDE_W($bits(mid_t))) u_sqrt_norm (
    .clk, .rst, .en,
    .in_valid (ve),
    .rad      (rad_e),
    .side_in  (mid_e),
    .out_valid(v_norm),
    .root     (norm),
    .side_out (mid_f)
  );

  tail_t tail_f;
  always_comb begin
    tail_f.l1   = mid_f.l1;
    tail_f.l2   = mid_f.l2;
    tail_f.bneg = mid_f.bneg;
    tail_f.diag = mid_f.diag;
    tail_f.agt  = mid_f.agt;
  end

  logic             v_q;
  logic [QUO_W-1:0] q_r, q_s;
  tail_t            tail_q;
  sed_div #(.DEN_W(ROOT_W), .FRAC_W(FRAC_W), .SIDE_W($bits(tail_t))) u_div (
    .clk, .rst, .en,
    .in_valid (v_norm),
    .m0       (ROOT_W'(mid_f.ur)),
    .m1       (ROOT_W'(mid_f.us)),
    .den      (norm),
    .side_in  (tail_f),
    .out_valid(v_q),
    .q0       (q_r),
    .q1       (q_s),
    .side_out (tail_q)
  );

  // output register
  logic [VEC_W-1:0] e0_next, e1_next, e2_next;
  always_comb begin
    if (tail_q.diag) begin
      e0_next = tail_q.agt ? ONE_Q30 : '0;
      e1_next = tail_q.agt ? '0 : ONE_Q30;
      e2_next = e1_next;
    end else begin
      e0_next = tail_q.bneg ? -VEC_W'(q_r) : VEC_W'(q_r);
      e1_next = VEC_W'(q_s);
      e2_next = -VEC_W'(q_s);  // s is never positive
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= v_q;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      larger_eigenvalue  <= tail_q.l1;
      smaller_eigenvalue <= tail_q.l2;
      vec_elem_0         <= e0_next;
      vec_elem_1         <= e1_next;
      vec_elem_2         <= e2_next;
      vec_elem_3         <= e0_next;
    end
  end

endmodule
`default_nettype wire

// ===== src/sed_sqrt.sv =====
// Pipelined floor square root, one result bit per register stage,
// with side data carried alongside. No package dependencies.
`default_nettype none
module sed_sqrt #(
  parameter int RAD_W  = 72,
  parameter int SIDE_W = 1
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  en,
  input  wire logic                  in_valid,
  input  wire logic [RAD_W-1:0]      rad,
  input  wire logic [SIDE_W-1:0]     side_in,
  output logic                       out_valid,
  output logic [RAD_W/2-1:0]         root,
  output logic [SIDE_W-1:0]          side_out
);
  localparam int RW    = RAD_W / 2;
  localparam int REM_W = RW + 3;

  logic              vld [0:RW];
  logic [RAD_W-1:0]  rd  [0:RW];
  logic [REM_W-1:0]  rm  [0:RW];
  logic [RW-1:0]     rt  [0:RW];
  logic [SIDE_W-1:0] sd  [0:RW];

  assign vld[0] = in_valid;
  assign rd[0]  = rad;
  assign rm[0]  = '0;
  assign rt[0]  = '0;
  assign sd[0]  = side_in;

  for (genvar k = 1; k <= RW; k++) begin : g_step
    logic [REM_W-1:0] cur;
    logic [REM_W-1:0] trial;
    logic             ge;

    always_comb begin
      cur   = {rm[k-1][REM_W-3:0], rd[k-1][RAD_W-1 -: 2]};
      trial = {1'b0, rt[k-1], 2'b01};
      ge    = (cur >= trial);
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k] <= 1'b0;
      end else if (en) begin
        vld[k] <= vld[k-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rd[k] <= rd[k-1] << 2;
        rm[k] <= ge ? cur - trial : cur;
        rt[k] <= {rt[k-1][RW-2:0], ge};
        sd[k] <= sd[k-1];
      end
    end
  end

  assign out_valid = vld[RW];
  assign root      = rt[RW];
  assign side_out  = sd[RW];

endmodule
`default_nettype wire

// ===== src/sed_div.sv =====
// Two-lane pipelined rounded divider: round(m * 2^FRAC_W / n) for m <= n,
// one quotient bit per stage, lanes share the divisor. No package dependencies.
`default_nettype none
module sed_div #(
  parameter int DEN_W  = 36,
  parameter int FRAC_W = 30,
  parameter int SIDE_W = 1
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  en,
  input  wire logic                  in_valid,
  input  wire logic [DEN_W-1:0]      m0,
  input  wire logic [DEN_W-1:0]      m1,
  input  wire logic [DEN_W-1:0]      den,
  input  wire logic [SIDE_W-1:0]     side_in,
  output logic                       out_valid,
  output logic [FRAC_W:0]            q0,
  output logic [FRAC_W:0]            q1,
  output logic [SIDE_W-1:0]          side_out
);
  localparam int Q_W   = FRAC_W + 1;
  localparam int NUM_W = DEN_W + Q_W;

  logic              vld [0:Q_W];
  logic [DEN_W-1:0]  dn  [0:Q_W];
  logic [SIDE_W-1:0] sd  [0:Q_W];
  logic [DEN_W-1:0]  rm  [0:1][0:Q_W];
  logic [Q_W-1:0]    lo  [0:1][0:Q_W];
  logic [Q_W-1:0]    qt  [0:1][0:Q_W];
  logic [NUM_W-1:0]  num [0:1];

  // numerator m * 2^FRAC_W + n/2; since m <= n the quotient fits Q_W bits
  always_comb begin
    num[0] = ({{(Q_W){1'b0}}, m0} << FRAC_W) + NUM_W'(den >> 1);
    num[1] = ({{(Q_W){1'b0}}, m1} << FRAC_W) + NUM_W'(den >> 1);
  end

  assign vld[0] = in_valid;
  assign dn[0]  = den;
  assign sd[0]  = side_in;

  for (genvar ln = 0; ln < 2; ln++) begin : g_init
    assign rm[ln][0] = num[ln][NUM_W-1:Q_W];
    assign lo[ln][0] = num[ln][Q_W-1:0];
    assign qt[ln][0] = '0;
  end

  for (genvar k = 1; k <= Q_W; k++) begin : g_step
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k] <= 1'b0;
      end else if (en) begin
        vld[k] <= vld[k-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        dn[k] <= dn[k-1];
        sd[k] <= sd[k-1];
      end
    end

    for (genvar ln = 0; ln < 2; ln++) begin : g_lane
      logic [DEN_W:0] cur;
      logic [DEN_W:0] diff;
      logic           ge;

      always_comb begin
        cur  = {rm[ln][k-1], lo[ln][k-1][Q_W-1]};
        diff = cur - {1'b0, dn[k-1]};
        ge   = (cur >= {1'b0, dn[k-1]});
      end

      always_ff @(posedge clk) begin
        if (en) begin
          rm[ln][k] <= ge ? diff[DEN_W-1:0] : cur[DEN_W-1:0];
          lo[ln][k] <= lo[ln][k-1] << 1;
          qt[ln][k] <= {qt[ln][k-1][Q_W-2:0], ge};
        end
      end
    end
  end

  assign out_valid = vld[Q_W];
  assign q0        = qt[0][Q_W];
  assign q1        = qt[1][Q_W];
  assign side_out  = sd[Q_W];

endmodule
`default_nettype wire

// ===== src/sed_checker.sv =====
// Port-level assertions for the eigendecomposition core, bound to the top.
// Depends on sed_pkg.
`default_nettype none
module sed_port_checker
  import sed_pkg::*;
(
  input wire logic                    clk,
  input wire logic                    rst,
  input wire logic                    in_valid,
  input wire logic                    in_ready,
  input wire logic signed [IN_W-1:0]  entry_a,
  input wire logic signed [IN_W-1:0]  entry_b,
  input wire logic signed [IN_W-1:0]  entry_d,
  input wire logic                    out_valid,
  input wire logic                    out_ready,
  input wire logic signed [VAL_W-1:0] larger_eigenvalue,
  input wire logic signed [VAL_W-1:0] smaller_eigenvalue,
  input wire logic signed [VEC_W-1:0] vec_elem_0,
  input wire logic signed [VEC_W-1:0] vec_elem_1,
  input wire logic signed [VEC_W-1:0] vec_elem_2,
  input wire logic signed [VEC_W-1:0] vec_elem_3
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(larger_eigenvalue))
    else $error("result item dropped or changed while stalled");

  a_stall: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |-> !in_ready)
    else $error("input taken while pipeline is stalled");

  a_order: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> larger_eigenvalue >= smaller_eigenvalue)
    else $error("eigenvalues out of order");

  a_vec: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> vec_elem_3 == vec_elem_0 &&
                  (vec_elem_1 == -vec_elem_2 || vec_elem_1 == vec_elem_2))
    else $error("eigenvector matrix lost its structure");

  a_reset: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("result item valid right after reset");

endmodule

bind sym2x2_eigen_decomposition_core sed_port_checker u_sed_checker (.*);
`default_nettype wire

// ===== verif/sed_checker.sv =====
// Checker for the symmetric 2x2 eigendecomposition core: predicts each result
// from accepted input items and compares it with the output channel.
// Depends on sed_pkg.
`timescale 1ns / 1ps
module sed_checker
  import sed_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  input  logic                    in_ready,
  input  logic signed [IN_W-1:0]  entry_a,
  input  logic signed [IN_W-1:0]  entry_b,
  input  logic signed [IN_W-1:0]  entry_d,
  input  logic                    out_valid,
  input  logic                    out_ready,
  input  logic signed [VAL_W-1:0] larger_eigenvalue,
  input  logic signed [VAL_W-1:0] smaller_eigenvalue,
  input  logic signed [VEC_W-1:0] vec_elem_0,
  input  logic signed [VEC_W-1:0] vec_elem_1,
  input  logic signed [VEC_W-1:0] vec_elem_2,
  input  logic signed [VEC_W-1:0] vec_elem_3,
  output int                      mismatches,
  output int                      pending
);

  typedef struct packed {
    logic signed [VAL_W-1:0] l1;
    logic signed [VAL_W-1:0] l2;
    logic signed [VEC_W-1:0] v0;
    logic signed [VEC_W-1:0] v1;
    logic signed [VEC_W-1:0] v2;
    logic signed [VEC_W-1:0] v3;
  } eigen_res_t;

  eigen_res_t expected_eigen[$];

  function automatic logic [127:0] floor_sqrt(logic [127:0] n);
    logic [127:0] root;
    logic [127:0] cand;
    root = '0;
    for (int i = 35; i >= 0; i--) begin
      cand = root | (128'd1 << i);
      if (cand * cand <= n) root = cand;
    end
    return root;
  endfunction

  // |x| * 2^30 / n, nearest with halves away from zero, sign of x
  function automatic logic signed [VEC_W-1:0] unit_scale(longint x, logic [127:0] n);
    logic [127:0] m;
    logic [127:0] q;
    m = (x < 0) ? 128'(-x) : 128'(x);
    q = ((m << FRAC_W) + n / 2) / n;
    return (x < 0) ? -q[VEC_W-1:0] : q[VEC_W-1:0];
  endfunction

  function automatic eigen_res_t predict_eigen(longint a, longint b, longint d);
    eigen_res_t r;
    longint diff, r2, det, s2;
    logic [127:0] ud, ur, us, norm;
    if (b == 0) begin
      if (a > d) begin
        r.l1 = VAL_W'(a); r.l2 = VAL_W'(d);
        r.v0 = ONE_Q30; r.v1 = '0; r.v2 = '0; r.v3 = ONE_Q30;
      end else begin
        r.l1 = VAL_W'(d); r.l2 = VAL_W'(a);
        r.v0 = '0; r.v1 = ONE_Q30; r.v2 = ONE_Q30; r.v3 = '0;
      end
    end else begin
      diff = a - d;
      r2 = 2 * b;
      ud = (diff < 0) ? 128'(-diff) : 128'(diff);
      ur = (r2 < 0) ? 128'(-r2) : 128'(r2);
      det = longint'(floor_sqrt(ud * ud + ur * ur));
      s2 = diff - det;
      us = 128'(-s2);
      norm = floor_sqrt(ur * ur + us * us);
      r.l1 = VAL_W'((a + d + det) >>> 1);
      r.l2 = VAL_W'((a + d - det) >>> 1);
      r.v0 = unit_scale(r2, norm);
      r.v2 = unit_scale(s2, norm);
      r.v1 = -r.v2;
      r.v3 = r.v0;
    end
    return r;
  endfunction

  task automatic report_field(string name, longint exp_v, longint act_v, ref logic bad);
    if (exp_v != act_v) begin
      if (mismatches < 10)
        $display("%0t: %s mismatch: expected %0d, got %0d", $time, name, exp_v, act_v);
      bad = 1'b1;
    end
  endtask

  always @(posedge clk) begin
    eigen_res_t e;
    logic bad;
    if (rst) begin
      mismatches <= 0;
      pending <= 0;
    end else begin
      if (in_valid && in_ready)
        expected_eigen.push_back(predict_eigen(entry_a, entry_b, entry_d));
      if (out_valid && out_ready) begin
        if (expected_eigen.size() == 0) begin
          if (mismatches < 10) $display("%0t: result item with nothing expected", $time);
          mismatches <= mismatches + 1;
        end else begin
          e = expected_eigen.pop_front();
          bad = 1'b0;
          report_field("larger_eigenvalue", e.l1, larger_eigenvalue, bad);
          report_field("smaller_eigenvalue", e.l2, smaller_eigenvalue, bad);
          report_field("vec_elem_0", e.v0, vec_elem_0, bad);
          report_field("vec_elem_1", e.v1, vec_elem_1, bad);
          report_field("vec_elem_2", e.v2, vec_elem_2, bad);
          report_field("vec_elem_3", e.v3, vec_elem_3, bad);
          if (bad) mismatches <= mismatches + 1;
        end
      end
      pending <= expected_eigen.size();
    end
  end

endmodule

// ===== verif/tb.sv =====
// Top of the eigendecomposition testbench: clock, reset, stimulus, output
// stalls and verdict. Depends on sed_pkg, sed_checker and the core.
`timescale 1ns / 1ps
module tb;
  import sed_pkg::*;

  localparam int RANDOM_ITEMS = 730;
  localparam int STALL_LIMIT  = 5000;

  logic clk, rst;
  logic in_valid, in_ready, out_valid, out_ready;
  logic signed [IN_W-1:0] entry_a, entry_b, entry_d;
  logic signed [VAL_W-1:0] larger_eigenvalue, smaller_eigenvalue;
  logic signed [VEC_W-1:0] vec_elem_0, vec_elem_1, vec_elem_2, vec_elem_3;
  int mismatches, pending;
  int cycle_count;
  int idle_cycles;
  logic calm;  // no idling on either side while set

  sym2x2_eigen_decomposition_core dut (.*);
  sed_checker chk (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) cycle_count <= cycle_count + 1;

  // watchdog: cycles with no item accepted on either channel
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  // receiver: random stalls, a calm stretch, and one long hold-off
  initial begin
    int held;
    out_ready = 1'b0;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (cycle_count == 600) begin
        out_ready <= 1'b0;
        for (held = 0; held < 400; held++) @(posedge clk);
        out_ready <= 1'b1;
      end else if (calm) begin
        out_ready <= 1'b1;
      end else begin
        out_ready <= ($urandom_range(99) >= 17);
      end
    end
  end

  task automatic send_matrix(logic [31:0] a, logic [31:0] b, logic [31:0] d);
    in_valid <= 1'b1;
    entry_a <= a;
    entry_b <= b;
    entry_d <= d;
    do @(posedge clk); while (!in_ready);
    if (!calm && $urandom_range(99) < 8) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  function automatic logic [31:0] rand_entry();
    case ($urandom_range(5))
      0: return $urandom_range(1) ? 32'h7fffffff : 32'h80000000;
      1: return 32'($signed($urandom_range(512)) - 256);
      2: return 32'($signed($urandom_range(1 << 20)) - (1 << 19));
      default: return $urandom;
    endcase
  endfunction

  initial begin
    logic [31:0] a, b, d;
    rst = 1'b1;
    in_valid = 1'b0;
    entry_a = '0; entry_b = '0; entry_d = '0;
    cycle_count = 0;
    idle_cycles = 0;
    calm = 1'b1;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // diagonal cases, all-zero, equal diagonal, off-diagonal cases, extremes
    send_matrix(0, 0, 0);
    send_matrix(32'h00010000, 0, 0);
    send_matrix(0, 0, 32'h00010000);
    send_matrix(32'h00050000, 0, 32'h00050000);
    send_matrix(32'h7fffffff, 0, 32'h80000000);
    send_matrix(32'h80000000, 0, 32'h7fffffff);
    send_matrix(0, 32'h00010000, 0);
    send_matrix(0, 32'hffff0000, 0);
    send_matrix(32'h7fffffff, 32'h7fffffff, 32'h7fffffff);
    send_matrix(32'h80000000, 32'h80000000, 32'h80000000);
    send_matrix(32'h80000000, 32'h7fffffff, 32'h7fffffff);
    send_matrix(32'h7fffffff, 32'h80000000, 32'h80000000);
    send_matrix(32'h80000000, 32'h80000000, 32'h7fffffff);
    send_matrix(32'h7fffffff, 32'h00000001, 32'h80000000);
    send_matrix(32'h80000000, 32'hffffffff, 32'h7fffffff);
    send_matrix(32'h00000001, 32'h00000001, 32'h00000001);
    send_matrix(32'hffffffff, 32'hffffffff, 32'h00000000);
    send_matrix(32'h00020000, 32'h00010000, 32'h00020000);
    send_matrix(32'h00030000, 32'hfffe0000, 32'hffff0000);
    send_matrix(32'haaaaaaaa, 32'h55555555, 32'haaaaaaaa);
    send_matrix(32'h55555555, 32'haaaaaaaa, 32'h55555555);

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i == 150) calm = 1'b0;
      if (i == 400) begin
        // sender pause: let every result drain
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
      end
      a = rand_entry();
      d = ($urandom_range(9) == 0) ? a : rand_entry();
      b = ($urandom_range(7) == 0) ? 32'd0 : rand_entry();
      send_matrix(a, b, d);
    end
    in_valid <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (150) @(posedge clk);
    if (mismatches == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule

// ===== sym2x2_eigen_decomposition_core.f =====
src/sed_pkg.sv
src/sed_sqrt.sv
src/sed_div.sv
src/sym2x2_eigen_decomposition_core.sv
src/sed_checker.sv
verif/sed_checker.sv
verif/tb.sv
